[sv/tilerect_pkg.sv]
package tilerect_pkg;

    localparam int GID_W      = 16;
    localparam int ENTRY_W    = 16;
    localparam int TS_IDX_W   = 2;
    localparam int SRC_X_W    = 20;
    localparam int SRC_Y_W    = 24;
    localparam int DEST_W     = 24;
    localparam int LW_W       = 13;
    localparam int TSZ_W      = 9;
    localparam int SCL_W      = 5;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_CNT_W  = 5;
    localparam int MUL_CNT_W  = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 96;

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILESET_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_IDS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS       = 3'd5;

    localparam logic [TSZ_W-1:0]  TSZ_MAX    = 9'd256;
    localparam logic [TSZ_W-1:0]  TSZ_RESET  = 9'd16;
    localparam logic [SCL_W-1:0]  SCL_MAX    = 5'd16;
    localparam logic [DEST_W-1:0] SRC_X_MAX  = 24'd1048575;
    localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 4'd9;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[sv/tile_id_to_tileset_rect.sv]
// A nonzero id runs through the bit-serial divider, one quotient bit at a time, then
// the shift-add source multiply, one tile size bit at a time; no new id is taken until
// the result is loaded. A zero id only advances the cell position and yields no result.
// The output register lets the next id be accepted while a result waits on m_tready.
// Reset (aresetn low, synchronous): counters cleared, registers to defaults, no result held.
module tile_id_to_tileset_rect #(
    parameter int NUM_TILESETS  = 4,
    parameter int MAX_LAYER_DIM = 4096
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [tilerect_pkg::IN_DATA_W-1:0]     s_tdata,  // tile_gid
    input  logic [0:0]                             s_tuser,  // layer_start
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tileset_index, source_x, source_y, dest_x, dest_y, zero pad
    output logic [tilerect_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [0:0]                             m_tuser,  // unmapped
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tilerect_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tilerect_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW   = $clog2(MAX_LAYER_DIM);
    localparam int TS_W = tilerect_pkg::ENTRY_W * NUM_TILESETS;
    localparam logic [tilerect_pkg::LW_W-1:0]  LW_MAX  = tilerect_pkg::LW_W'(MAX_LAYER_DIM);
    localparam logic [CW-1:0]                  ROW_MAX = CW'(MAX_LAYER_DIM - 1);
    localparam logic [tilerect_pkg::CNT_W-1:0] NUM_TS  = tilerect_pkg::CNT_W'(NUM_TILESETS);

    localparam int GW = tilerect_pkg::GID_W;
    localparam int DW = tilerect_pkg::DEST_W;
    localparam int TW = tilerect_pkg::TSZ_W;

    tilerect_pkg::state_t state_reg, state_next;

    logic [CW:0]                         width_reg;
    logic [TW-1:0]                       tsz_reg;
    logic [tilerect_pkg::SCL_W-1:0]      scl_reg;
    logic [tilerect_pkg::CNT_W-1:0]      tscount_reg;
    logic [TS_W-1:0]                     first_ids_reg;
    logic [TS_W-1:0]                     columns_reg;

    logic [CW-1:0]                       col_reg;
    logic [CW-1:0]                       row_reg;

    logic [CW-1:0]                       col_sh_reg;
    logic [CW-1:0]                       row_sh_reg;
    logic [DW-1:0]                       step_sh_reg;
    logic [DW-1:0]                       dx_reg;
    logic [DW-1:0]                       dy_reg;
    logic [DW-1:0]                       sx_reg;
    logic [DW-1:0]                       sy_reg;
    logic [TW-1:0]                       tsz_sh_reg;
    logic [tilerect_pkg::MUL_CNT_W-1:0]  mul_cnt_reg;
    logic                                found_reg;
    logic [tilerect_pkg::TS_IDX_W-1:0]   idx_reg;

    logic                                m_tvalid_reg;
    logic [tilerect_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                                m_unmapped_reg;

    logic                                in_xfer;
    logic                                item_start;
    logic                                out_free;
    logic                                out_load;

    logic [GW-1:0]                       gid;
    logic [CW-1:0]                       cur_col;
    logic [CW-1:0]                       cur_row;
    logic [CW:0]                         col_inc;
    logic                                found;
    logic [tilerect_pkg::TS_IDX_W-1:0]   best_idx;
    logic [GW-1:0]                       best_first;
    logic [GW-1:0]                       best_cols;
    logic [GW-1:0]                       entry_first;
    logic [GW-1:0]                       local_idx;
    logic [GW-1:0]                       div_cols;
    logic [13:0]                         step;
    logic [DW-1:0]                       sx_sat;

    logic [tilerect_pkg::LW_W-1:0]       cfg_lw;
    logic [TW-1:0]                       cfg_tsz;
    logic [tilerect_pkg::SCL_W-1:0]      cfg_scl;
    logic [tilerect_pkg::CNT_W-1:0]      cfg_cnt;

    tilerect_pkg::div_status_t           div_st;
    logic [GW-1:0]                       div_quo;
    logic [GW-1:0]                       div_rem;

    assign cfg_ready = 1'b1;
    assign gid       = s_tdata[GW-1:0];
    assign in_xfer   = s_tvalid && s_tready;
    assign item_start = in_xfer && (gid != '0);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next state and handshake
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            tilerect_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (item_start) begin
                    state_next = tilerect_pkg::ST_DIV;
                end
            end
            tilerect_pkg::ST_DIV: begin
                if (div_st.done) begin
                    state_next = tilerect_pkg::ST_MUL;
                end
            end
            tilerect_pkg::ST_MUL: begin
                if (mul_cnt_reg == 1) begin
                    state_next = tilerect_pkg::ST_DONE;
                end
            end
            tilerect_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = tilerect_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tilerect_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tilerect_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Tileset selection and divider operands
    always_comb begin
        found      = 1'b0;
        best_idx   = '0;
        best_first = '0;
        best_cols  = '0;
        for (int i = 0; i < NUM_TILESETS; i++) begin
            entry_first = first_ids_reg[i*tilerect_pkg::ENTRY_W +: tilerect_pkg::ENTRY_W];
            if ((tilerect_pkg::CNT_W'(i) < tscount_reg) && (entry_first <= gid) &&
                (!found || (entry_first > best_first))) begin
                found      = 1'b1;
                best_idx   = tilerect_pkg::TS_IDX_W'(i);
                best_first = entry_first;
                best_cols  = columns_reg[i*tilerect_pkg::ENTRY_W +: tilerect_pkg::ENTRY_W];
            end
        end
        local_idx = found ? (gid - best_first) : '0;
        div_cols  = (!found || (best_cols == '0)) ? GW'(1) : best_cols;
    end

    assign step    = 14'(tsz_reg) * 14'(scl_reg);
    assign cur_col = s_tuser[0] ? '0 : col_reg;
    assign cur_row = s_tuser[0] ? '0 : row_reg;
    assign col_inc = {1'b0, cur_col} + 1'b1;

    // Configuration, scalar fields clamped on write
    assign cfg_lw  = cfg_data[tilerect_pkg::LW_W-1:0];
    assign cfg_tsz = cfg_data[TW-1:0];
    assign cfg_scl = cfg_data[tilerect_pkg::SCL_W-1:0];
    assign cfg_cnt = cfg_data[tilerect_pkg::CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= (CW+1)'(1);
            tsz_reg       <= tilerect_pkg::TSZ_RESET;
            scl_reg       <= tilerect_pkg::SCL_W'(1);
            tscount_reg   <= tilerect_pkg::CNT_W'(1);
            first_ids_reg <= TS_W'(1);
            columns_reg   <= TS_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tilerect_pkg::REG_LAYER_WIDTH: begin
                    if (cfg_lw == '0) begin
                        width_reg <= (CW+1)'(1);
                    end else if (cfg_lw > LW_MAX) begin
                        width_reg <= (CW+1)'(LW_MAX);
                    end else begin
                        width_reg <= (CW+1)'(cfg_lw);
                    end
                end
                tilerect_pkg::REG_TILE_SIZE: begin
                    if (cfg_tsz == '0) begin
                        tsz_reg <= TW'(1);
                    end else if (cfg_tsz > tilerect_pkg::TSZ_MAX) begin
                        tsz_reg <= tilerect_pkg::TSZ_MAX;
                    end else begin
                        tsz_reg <= cfg_tsz;
                    end
                end
                tilerect_pkg::REG_DRAW_SCALE: begin
                    if (cfg_scl == '0) begin
                        scl_reg <= tilerect_pkg::SCL_W'(1);
                    end else if (cfg_scl > tilerect_pkg::SCL_MAX) begin
                        scl_reg <= tilerect_pkg::SCL_MAX;
                    end else begin
                        scl_reg <= cfg_scl;
                    end
                end
                tilerect_pkg::REG_TILESET_COUNT: begin
                    if (cfg_cnt == '0) begin
                        tscount_reg <= tilerect_pkg::CNT_W'(1);
                    end else if (cfg_cnt > NUM_TS) begin
                        tscount_reg <= NUM_TS;
                    end else begin
                        tscount_reg <= cfg_cnt;
                    end
                end
                tilerect_pkg::REG_FIRST_IDS: begin
                    first_ids_reg <= cfg_data[TS_W-1:0];
                end
                tilerect_pkg::REG_COLUMNS: begin
                    columns_reg <= cfg_data[TS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Cell position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_xfer) begin
            if (col_inc >= width_reg) begin
                col_reg <= '0;
                row_reg <= (cur_row != ROW_MAX) ? cur_row + 1'b1 : cur_row;
            end else begin
                col_reg <= col_inc[CW-1:0];
                row_reg <= cur_row;
            end
        end
    end

    tilerect_sdiv u_sdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (item_start),
        .dividend  (local_idx),
        .divisor   (div_cols),
        .status    (div_st),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Serial datapath: destination shift-add during divide, source shift-add after
    always_ff @(posedge aclk) begin
        if (item_start) begin
            col_sh_reg  <= cur_col;
            row_sh_reg  <= cur_row;
            step_sh_reg <= DW'(step);
            dx_reg      <= '0;
            dy_reg      <= '0;
            found_reg   <= found;
            idx_reg     <= best_idx;
        end else if (state_reg == tilerect_pkg::ST_DIV) begin
            col_sh_reg  <= col_sh_reg >> 1;
            row_sh_reg  <= row_sh_reg >> 1;
            step_sh_reg <= {step_sh_reg[DW-2:0], 1'b0};
            dx_reg      <= dx_reg + (col_sh_reg[0] ? step_sh_reg : '0);
            dy_reg      <= dy_reg + (row_sh_reg[0] ? step_sh_reg : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_cnt_reg <= '0;
        end else if ((state_reg == tilerect_pkg::ST_DIV) && div_st.done) begin
            mul_cnt_reg <= tilerect_pkg::MUL_STEPS;
        end else if (state_reg == tilerect_pkg::ST_MUL) begin
            mul_cnt_reg <= mul_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == tilerect_pkg::ST_DIV) && div_st.done) begin
            tsz_sh_reg <= tsz_reg;
            sx_reg     <= '0;
            sy_reg     <= '0;
        end else if (state_reg == tilerect_pkg::ST_MUL) begin
            tsz_sh_reg <= {tsz_sh_reg[TW-2:0], 1'b0};
            sx_reg     <= {sx_reg[DW-2:0], 1'b0} + (tsz_sh_reg[TW-1] ? DW'(div_rem) : '0);
            sy_reg     <= {sy_reg[DW-2:0], 1'b0} + (tsz_sh_reg[TW-1] ? DW'(div_quo) : '0);
        end
    end

    assign sx_sat = (sx_reg > tilerect_pkg::SRC_X_MAX) ? tilerect_pkg::SRC_X_MAX : sx_reg;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, dy_reg, dx_reg, sy_reg,
                            sx_sat[tilerect_pkg::SRC_X_W-1:0], idx_reg};
            m_unmapped_reg <= !found_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_unmapped_reg;

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_st.busy)
        else $error("input accepted while divider busy");

    a_start_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        item_start |=> (state_reg == tilerect_pkg::ST_DIV) && div_st.busy)
        else $error("nonzero id did not start the divider");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == tilerect_pkg::ST_DIV))
        else $error("divider finished outside divide phase");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (row_reg <= ROW_MAX))
        else $error("row counter beyond layer limit");

endmodule

[sv/tilerect_sdiv.sv]
module tilerect_sdiv (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [tilerect_pkg::GID_W-1:0]      dividend,
    input  logic [tilerect_pkg::GID_W-1:0]      divisor,
    output tilerect_pkg::div_status_t           status,
    output logic [tilerect_pkg::GID_W-1:0]      quotient,
    output logic [tilerect_pkg::GID_W-1:0]      remainder
);

    logic [tilerect_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic [tilerect_pkg::GID_W-1:0]     dvd_reg;
    logic [tilerect_pkg::GID_W-1:0]     dvs_reg;
    logic [tilerect_pkg::GID_W-1:0]     rem_reg;
    logic [tilerect_pkg::GID_W-1:0]     quo_reg;
    logic [tilerect_pkg::GID_W:0]       trial;
    logic [tilerect_pkg::GID_W:0]       diff;
    logic                               qbit;

    always_comb begin
        trial = {rem_reg, dvd_reg[tilerect_pkg::GID_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= tilerect_pkg::DIV_STEPS;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[tilerect_pkg::GID_W-2:0], 1'b0};
            rem_reg <= qbit ? diff[tilerect_pkg::GID_W-1:0] : trial[tilerect_pkg::GID_W-1:0];
            quo_reg <= {quo_reg[tilerect_pkg::GID_W-2:0], qbit};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule
